>>> hdl/rsdpc_pkg.sv
// Shared widths and constants for the per-cell running deviation block.
package rsdpc_pkg;

  localparam int unsigned CELL_COUNT_DEF = 1024;
  localparam int unsigned CELL_COUNT_MAX = 65536;

  localparam int unsigned CELL_W   = 10;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DEV_W    = 32;
  localparam int unsigned SUM_W    = 64;

  // Wide enough to compare a cell index against the largest cell count.
  localparam int unsigned IDX_EXT_W = 17;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;

  // Shared subtractor: square root trial is 36 bits wide.
  localparam int unsigned ALU_W  = 36;
  localparam int unsigned SREM_W = 34;

  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CNT_W      = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

>>> hdl/running_std_deviation_per_cell_core.sv
// Per-cell running standard deviation with an iterative divider and square root.
//
// Input stream (s_axis): one word per update request carrying the cell index,
// the zero-based step count, the sample and the mean (unsigned Q24.8).
// Output stream (m_axis): one word per request with the cell's deviation in
// tdata and the flags updated / sum_saturated in tuser.
//
// A request with a nonzero step count adds (sample - mean)^2 to the cell's
// sum, then divides the sum by the step count one quotient bit a cycle and
// takes the square root two radicand bits a cycle. Both loops run through
// one shared subtractor. The result passes through the output register, and
// the next word is taken once the sequencer returns to idle after handoff.
// A step count of zero returns the stored deviation without dividing; an
// out-of-range cell returns zeros and leaves both memories untouched.
// s_axis_tready is high only while the sequencer waits for a word.
// After reset the block sweeps both per-cell memories to zero, one entry a
// cycle with s_axis_tready low. A finished result sits in the output
// register; if the receiver stalls, the next word is still taken and worked
// on, and only its final handoff waits for the register to free up.
module running_std_deviation_per_cell_core #(
  parameter int unsigned CELL_COUNT = rsdpc_pkg::CELL_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] cell_req, [29:10] step_count, [61:30] sample, [93:62] mean
  input  logic [rsdpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] std_dev
  output logic [rsdpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] updated, [1] sum_saturated
  output logic [rsdpc_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned CW = rsdpc_pkg::CELL_W;
  localparam int unsigned SW = rsdpc_pkg::STEP_W;
  localparam int unsigned DW = rsdpc_pkg::DEV_W;
  localparam int unsigned UW = rsdpc_pkg::SUM_W;
  localparam int unsigned XW = rsdpc_pkg::IDX_EXT_W;
  localparam int unsigned AL = rsdpc_pkg::ALU_W;
  localparam int unsigned RW = rsdpc_pkg::SREM_W;
  localparam int unsigned NW = rsdpc_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_cnt_q;
  logic [CW-1:0]   cell_q;
  logic [SW-1:0]   step_q;
  logic [31:0]     diff_q;
  logic [UW-1:0]   sq_q;
  logic [UW-1:0]   dq_q;
  logic [RW-1:0]   rem_q;
  logic [DW-1:0]   root_q;
  logic [NW-1:0]   cnt_q;
  logic [DW-1:0]   res_dev_q;
  logic            res_upd_q;
  logic            res_sat_q;
  logic            out_valid_q;
  logic [DW-1:0]   out_dev_q;
  logic            out_upd_q;
  logic            out_sat_q;

  logic [UW-1:0]   sum_mem_q [CELL_COUNT];
  logic [DW-1:0]   dev_mem_q [CELL_COUNT];
  logic [UW-1:0]   sum_rd_q;
  logic [DW-1:0]   dev_rd_q;

  // Input fields
  logic [CW-1:0]   in_cell;
  logic [SW-1:0]   in_step;
  logic [31:0]     in_sample;
  logic [31:0]     in_mean;
  logic            accept;
  logic            in_range;

  assign in_cell   = s_axis_tdata[9:0];
  assign in_step   = s_axis_tdata[29:10];
  assign in_sample = s_axis_tdata[61:30];
  assign in_mean   = s_axis_tdata[93:62];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_range  = {{(XW-CW){1'b0}}, in_cell} < XW'(CELL_COUNT);

  // Memory addressing
  logic [XW-1:0]   cell_ext;
  logic [AW-1:0]   cell_addr;
  assign cell_ext  = {{(XW-CW){1'b0}}, cell_q};
  assign cell_addr = cell_ext[AW-1:0];

  // Saturating accumulate
  logic [UW:0]     sum_add;
  logic [UW-1:0]   sum_new;
  assign sum_add = {1'b0, sum_rd_q} + {1'b0, sq_q};
  assign sum_new = sum_add[UW] ? rsdpc_pkg::SUM_MAX : sum_add[UW-1:0];

  // Shared subtractor for the divide and square root loops
  logic [AL-1:0]   alu_a;
  logic [AL-1:0]   alu_b;
  logic [AL:0]     alu_diff;
  logic            alu_ge;

  always_comb begin
    if (state_q == ST_SQRT) begin
      alu_a = {rem_q, dq_q[UW-1:UW-2]};
      alu_b = {2'b00, root_q, 2'b01};
    end else begin
      alu_a = {{(AL-SW-1){1'b0}}, rem_q[SW-1:0], dq_q[UW-1]};
      alu_b = {{(AL-SW){1'b0}}, step_q};
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[AL];

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Memory ports
  logic            sum_we;
  logic            dev_we;
  logic [AW-1:0]   wr_addr;
  logic [UW-1:0]   sum_wdata;
  logic [DW-1:0]   dev_wdata;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      sum_we    = 1'b1;
      dev_we    = 1'b1;
      wr_addr   = clr_cnt_q;
      sum_wdata = '0;
      dev_wdata = '0;
    end else begin
      sum_we    = (state_q == ST_CALC) && (step_q != '0);
      dev_we    = (state_q == ST_DONE) && res_upd_q && out_free;
      wr_addr   = cell_addr;
      sum_wdata = sum_new;
      dev_wdata = res_dev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem_q[wr_addr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem_q[cell_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dev_we) begin
      dev_mem_q[wr_addr] <= dev_wdata;
    end
    dev_rd_q <= dev_mem_q[cell_addr];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cell_q      <= '0;
      step_q      <= '0;
      diff_q      <= '0;
      sq_q        <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      cnt_q       <= '0;
      res_dev_q   <= '0;
      res_upd_q   <= 1'b0;
      res_sat_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_dev_q   <= '0;
      out_upd_q   <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      // Load on handoff, drop once the receiver takes the word.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(CELL_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cell_q <= in_cell;
            step_q <= in_step;
            diff_q <= (in_sample >= in_mean) ? (in_sample - in_mean)
                                             : (in_mean - in_sample);
            if (in_range) begin
              state_q <= ST_READ;
            end else begin
              res_dev_q <= '0;
              res_upd_q <= 1'b0;
              res_sat_q <= 1'b0;
              state_q   <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          sq_q    <= UW'(diff_q) * UW'(diff_q);
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          if (step_q == '0) begin
            res_dev_q <= dev_rd_q;
            res_upd_q <= 1'b0;
            res_sat_q <= (sum_rd_q == rsdpc_pkg::SUM_MAX);
            state_q   <= ST_DONE;
          end else begin
            res_sat_q <= (sum_new == rsdpc_pkg::SUM_MAX);
            dq_q      <= sum_new;
            rem_q     <= '0;
            cnt_q     <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division: one quotient bit shifts in per cycle.
          dq_q <= {dq_q[UW-2:0], alu_ge};
          if (cnt_q == NW'(rsdpc_pkg::DIV_STEPS - 1)) begin
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end else begin
            rem_q <= {{(RW-SW){1'b0}},
                      alu_ge ? alu_diff[SW-1:0] : alu_a[SW-1:0]};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SQRT: begin
          // Digit-by-digit root: two radicand bits per cycle.
          dq_q   <= {dq_q[UW-3:0], 2'b00};
          rem_q  <= alu_ge ? alu_diff[RW-1:0] : alu_a[RW-1:0];
          root_q <= {root_q[DW-2:0], alu_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == NW'(rsdpc_pkg::SQRT_STEPS - 1)) begin
            res_dev_q <= {root_q[DW-2:0], alu_ge};
            res_upd_q <= 1'b1;
            state_q   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            out_dev_q   <= res_dev_q;
            out_upd_q   <= res_upd_q;
            out_sat_q   <= res_sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_dev_q;
  assign m_axis_tuser  = {out_sat_q, out_upd_q};

  // A word taken starts the sequencer; no second word until it returns.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input taken while an update is in progress");

  // The divider never runs on a zero step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q != '0))
    else $error("division started with a zero divisor");

  // No result can leave while the memories are still being swept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_axis_tvalid)
    else $error("output valid during the clearing sweep");

  // The deviation store is written only once a result is handed off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && dev_we) |=> (m_axis_tvalid && (state_q == ST_IDLE)))
    else $error("deviation written without a result going out");

endmodule

>>> tb/sv/running_std_deviation_per_cell_core_tb.sv
// Self-checking bench for the per-cell running deviation core: directed and random requests.
module running_std_deviation_per_cell_core_tb;

  localparam int unsigned CELLS       = rsdpc_pkg::CELL_COUNT_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned RAND_ITEMS  = 630;

  typedef enum logic [1:0] {
    IDLE_SRC_HEAVY,
    IDLE_SINK_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [rsdpc_pkg::DEV_W-1:0] std_dev;
    logic                        updated;
    logic                        sum_sat;
  } dev_word_t;

  // Tracks per-cell square sums and deviations, holds the words still owed by the core.
  class cell_deviation_tracker;
    logic [rsdpc_pkg::SUM_W-1:0] sq_total [CELLS];
    logic [rsdpc_pkg::DEV_W-1:0] dev_held [CELLS];
    dev_word_t                   owed_q[$];
    int unsigned                 mismatches;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        sq_total[i] = '0;
        dev_held[i] = '0;
      end
      mismatches = 0;
    endfunction

    function logic [rsdpc_pkg::DEV_W-1:0] root_floor(logic [rsdpc_pkg::SUM_W-1:0] v);
      logic [rsdpc_pkg::DEV_W-1:0] root;
      logic [rsdpc_pkg::DEV_W-1:0] trial;
      root = '0;
      for (int b = rsdpc_pkg::DEV_W - 1; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if ({32'b0, trial} * {32'b0, trial} <= v) root = trial;
      end
      return root;
    endfunction

    function dev_word_t predict_deviation(logic [rsdpc_pkg::CELL_W-1:0]   cell_idx,
                                          logic [rsdpc_pkg::STEP_W-1:0]   step,
                                          logic [rsdpc_pkg::SAMPLE_W-1:0] smp,
                                          logic [rsdpc_pkg::SAMPLE_W-1:0] avg);
      dev_word_t                      w;
      logic [rsdpc_pkg::SAMPLE_W-1:0] diff;
      logic [rsdpc_pkg::SUM_W:0]      wide;
      w = '0;
      // An index past the cell count is dropped and answered with zeros.
      if (cell_idx >= CELLS) return w;
      if (step != 0) begin
        diff = (smp >= avg) ? smp - avg : avg - smp;
        wide = {1'b0, sq_total[cell_idx]} + {33'b0, diff} * {33'b0, diff};
        sq_total[cell_idx] = wide[rsdpc_pkg::SUM_W] ? rsdpc_pkg::SUM_MAX
                                                    : wide[rsdpc_pkg::SUM_W-1:0];
        dev_held[cell_idx] = root_floor(sq_total[cell_idx] / {44'b0, step});
        w.updated = 1'b1;
      end
      w.std_dev = dev_held[cell_idx];
      w.sum_sat = (sq_total[cell_idx] == rsdpc_pkg::SUM_MAX);
      return w;
    endfunction

    function void note_request(logic [rsdpc_pkg::IN_DATA_W-1:0] data);
      owed_q.push_back(predict_deviation(data[9:0], data[29:10], data[61:30], data[93:62]));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_word(logic [rsdpc_pkg::OUT_DATA_W-1:0] data,
                    logic [rsdpc_pkg::OUT_USER_W-1:0] user);
      dev_word_t w;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected word", 64'({user, data}), '0);
        return;
      end
      w = owed_q.pop_front();
      if (data !== w.std_dev) report_mismatch("std_dev", 64'(data), 64'(w.std_dev));
      if (user[0] !== w.updated) report_mismatch("updated", 64'(user[0]), 64'(w.updated));
      if (user[1] !== w.sum_sat) begin
        report_mismatch("sum_saturated", 64'(user[1]), 64'(w.sum_sat));
      end
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rsdpc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rsdpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [rsdpc_pkg::OUT_USER_W-1:0] m_axis_tuser;

  idle_mode_e                       idle_mode = IDLE_SRC_HEAVY;
  int unsigned                      words_out = 0;
  int unsigned                      quiet_cycles = 0;
  logic [rsdpc_pkg::STEP_W-1:0]     next_step [32];

  cell_deviation_tracker tracker = new();

  running_std_deviation_per_cell_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) tracker.note_request(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_word(m_axis_tdata, m_axis_tuser);
      words_out <= words_out + 1;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up.
  initial begin : sink
    int unsigned stall_pct;
    bit          held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_out >= 40) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      case (idle_mode)
        IDLE_SRC_HEAVY:  stall_pct = 46;
        IDLE_SINK_HEAVY: stall_pct = 38;
        default:         stall_pct = 0;
      endcase
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(logic [rsdpc_pkg::CELL_W-1:0]   cell_idx,
                              logic [rsdpc_pkg::STEP_W-1:0]   step,
                              logic [rsdpc_pkg::SAMPLE_W-1:0] smp,
                              logic [rsdpc_pkg::SAMPLE_W-1:0] avg);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SRC_HEAVY) ? 38 : (idle_mode == IDLE_SINK_HEAVY) ? 46 : 0;
    s_axis_tdata  <= {2'b00, avg, smp, step, cell_idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    // Idle for up to a little more than one full computation so gaps hit every stage.
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(120, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_request();
    logic [rsdpc_pkg::CELL_W-1:0]   cell_idx;
    logic [rsdpc_pkg::STEP_W-1:0]   step;
    logic [rsdpc_pkg::SAMPLE_W-1:0] smp;
    logic [rsdpc_pkg::SAMPLE_W-1:0] avg;
    int unsigned                    pick;
    bit                             pooled;
    pooled = ($urandom_range(99) < 70);
    cell_idx = pooled ? rsdpc_pkg::CELL_W'($urandom_range(31))
                      : rsdpc_pkg::CELL_W'($urandom_range(CELLS - 1));
    pick = $urandom_range(99);
    if (pooled && pick < 45) begin
      // Well-formed run: step counts climb per cell, as a real time series would.
      step = next_step[cell_idx[4:0]];
      next_step[cell_idx[4:0]] = next_step[cell_idx[4:0]] + 1;
    end else if (pick < 55) begin
      step = '0;
    end else if (pick < 75) begin
      step = rsdpc_pkg::STEP_W'($urandom_range(64, 1));
    end else if (pick < 92) begin
      step = rsdpc_pkg::STEP_W'($urandom_range(20'hFFFFF));
    end else begin
      step = '1;
    end
    pick = $urandom_range(99);
    smp  = $urandom;
    if (pick < 30) begin
      avg = $urandom;
    end else if (pick < 70) begin
      avg = smp + $urandom_range(65535) - 32768;
    end else if (pick < 90) begin
      smp = $urandom_range(32'h000F_FFFF);
      avg = $urandom_range(32'h000F_FFFF);
    end else begin
      avg = smp;
    end
    send_request(cell_idx, step, smp, avg);
  endtask

  initial begin : stimulus
    for (int i = 0; i < 32; i++) next_step[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh cell at step zero, then the largest difference, then saturation.
    send_request(10'd0, 20'd0, 32'd0, 32'd0);
    send_request(10'd0, 20'd1, 32'hFFFF_FFFF, 32'd0);
    send_request(10'd0, 20'd0, 32'h1234, 32'h1234);
    send_request(10'd0, 20'd1, 32'd0, 32'hFFFF_FFFF);
    send_request(10'd0, 20'd0, 32'd0, 32'd0);
    send_request(10'd0, 20'hFFFFF, 32'd5, 32'd7);
    // Top cell: zero difference at the largest step, mean above and below sample.
    send_request(10'd1023, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(10'd1023, 20'd1, 32'h100, 32'h300);
    send_request(10'd1023, 20'd0, 32'd0, 32'd0);
    send_request(10'd1023, 20'd2, 32'h300, 32'h100);
    send_request(10'h200, 20'd1, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(10'h155, 20'hAAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(10'h2AA, 20'h55555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(10'd1, 20'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(10'd1, 20'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    // Short ordered series on one cell.
    for (int s = 0; s < 6; s++) begin
      send_request(10'd2, rsdpc_pkg::STEP_W'(s), 32'h0000_1000 + 32'(s) * 32'h0000_0380,
                   32'h0000_1800);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) idle_mode <= IDLE_SINK_HEAVY;
      if (n == 2 * RAND_ITEMS / 3) idle_mode <= IDLE_NONE;
      send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> running_std_deviation_per_cell_core.f
hdl/rsdpc_pkg.sv
hdl/running_std_deviation_per_cell_core.sv
tb/sv/running_std_deviation_per_cell_core_tb.sv
